@@ hw/rtl/running_median_two_heaps_macros.svh @@
// Assertion macros for the running median block.
`ifndef RUNNING_MEDIAN_TWO_HEAPS_MACROS_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_MACROS_SVH
`ifndef SYNTHESIS
`define RMTH_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define RMTH_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`else
`define RMTH_ASSERT(lbl, expr, msg)
`define RMTH_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

@@ hw/rtl/rmth_pkg.sv @@
// Types, constants and helpers shared by the running median block.
package rmth_pkg;
	localparam int CAPACITY   = 1024;
	localparam int HEAP_DEPTH = CAPACITY / 2;
	localparam int IDX_W      = $clog2(HEAP_DEPTH);
	localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
	localparam int TOT_W      = 11;
	localparam int DATA_W     = 32;

	typedef enum logic {
		HEAP_LO,
		HEAP_UP
	} heap_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_POP_INIT,
		OP_POP_LOAD,
		OP_POP_STEP,
		OP_PUSH_INIT,
		OP_PUSH_STEP,
		OP_EMIT
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_POP_INIT,
		ST_POP_LOAD,
		ST_POP_STEP,
		ST_PUSH_M_INIT,
		ST_PUSH_M_STEP,
		ST_PUSH_X_INIT,
		ST_PUSH_X_STEP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		op_t   op;
		heap_t sel;
		logic  src_moved;
		logic  drop;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic lo_gt;
		logic up_gt;
		logic lo_nz;
		logic x_lt_lotop;
		logic x_le_lotop;
		logic x_gt_uptop;
		logic pop_empty;
		logic step_done;
	} status_t;

	// true if a sits above b in the given heap
	function automatic logic above(logic signed [DATA_W-1:0] a,
		logic signed [DATA_W-1:0] b, heap_t h);
		return (h == HEAP_UP) ? (a < b) : (a > b);
	endfunction
endpackage

@@ hw/rtl/rmth_datapath.sv @@
// Heap memories, counts, root mirrors, sift unit and output word register.
module rmth_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  rmth_pkg::cmd_t                        cmd,
	output rmth_pkg::status_t                     status,
	input  logic signed [rmth_pkg::DATA_W-1:0]    sample,
	output logic signed [rmth_pkg::DATA_W-1:0]    median,
	output logic                                  dropped,
	output logic [rmth_pkg::TOT_W-1:0]            stored_count
);
	import rmth_pkg::*;
	`include "running_median_two_heaps_macros.svh"

	logic signed [DATA_W-1:0] lo_mem [HEAP_DEPTH];
	logic signed [DATA_W-1:0] up_mem [HEAP_DEPTH];
	logic signed [DATA_W-1:0] lo_rda_q, lo_rdb_q, up_rda_q, up_rdb_q;

	logic [CNT_W-1:0] lcnt_q, ucnt_q, n_q;
	logic [IDX_W-1:0] idx_q;
	heap_t sel_q;
	logic signed [DATA_W-1:0] x_q, val_q, moved_q, lotop_q, uptop_q;
	logic signed [DATA_W-1:0] median_q;
	logic dropped_q;
	logic [TOT_W-1:0] count_q;

	logic [IDX_W-1:0] raddr_a, raddr_b, waddr, next_idx;
	logic signed [DATA_W-1:0] wdata, rd_a, rd_b, best_v;
	logic we, step_done, move;
	logic [CNT_W-1:0] cmd_cnt;
	logic [TOT_W-1:0] lchild, rchild, total;
	logic signed [DATA_W:0] sum, half;
	logic signed [DATA_W-1:0] med_next;

	assign rd_a    = (sel_q == HEAP_UP) ? up_rda_q : lo_rda_q;
	assign rd_b    = (sel_q == HEAP_UP) ? up_rdb_q : lo_rdb_q;
	assign cmd_cnt = (cmd.sel == HEAP_UP) ? ucnt_q : lcnt_q;
	assign lchild  = {1'b0, idx_q, 1'b1};
	assign rchild  = lchild + TOT_W'(1);
	assign total   = TOT_W'(lcnt_q) + TOT_W'(ucnt_q);

	always_comb begin
		raddr_a   = '0;
		raddr_b   = '0;
		waddr     = idx_q;
		wdata     = val_q;
		we        = 1'b0;
		step_done = 1'b0;
		move      = 1'b0;
		next_idx  = idx_q;
		best_v    = val_q;
		case (cmd.op)
			OP_POP_INIT: begin
				raddr_a = IDX_W'(cmd_cnt - CNT_W'(1));
			end
			OP_POP_LOAD: begin
				raddr_a = IDX_W'(1);
				raddr_b = IDX_W'(2);
			end
			OP_POP_STEP: begin
				if (lchild < TOT_W'(n_q) && above(rd_a, best_v, sel_q)) begin
					best_v   = rd_a;
					next_idx = lchild[IDX_W-1:0];
					move     = 1'b1;
				end
				if (rchild < TOT_W'(n_q) && above(rd_b, best_v, sel_q)) begin
					best_v   = rd_b;
					next_idx = rchild[IDX_W-1:0];
					move     = 1'b1;
				end
				we        = 1'b1;
				wdata     = move ? best_v : val_q;
				step_done = !move;
				raddr_a   = IDX_W'({next_idx, 1'b1});
				raddr_b   = IDX_W'({next_idx, 1'b1} + (IDX_W + 1)'(1));
			end
			OP_PUSH_INIT: begin
				raddr_a = IDX_W'((cmd_cnt - CNT_W'(1)) >> 1);
			end
			OP_PUSH_STEP: begin
				we       = 1'b1;
				next_idx = IDX_W'((idx_q - IDX_W'(1)) >> 1);
				if (idx_q != '0 && above(val_q, rd_a, sel_q)) begin
					wdata = rd_a;
					move  = 1'b1;
				end else begin
					wdata     = val_q;
					step_done = 1'b1;
				end
				raddr_a = IDX_W'((next_idx - IDX_W'(1)) >> 1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we && sel_q == HEAP_LO)
			lo_mem[waddr] <= wdata;
		if (we && sel_q == HEAP_UP)
			up_mem[waddr] <= wdata;
		lo_rda_q <= lo_mem[raddr_a];
		lo_rdb_q <= lo_mem[raddr_b];
		up_rda_q <= up_mem[raddr_a];
		up_rdb_q <= up_mem[raddr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcnt_q <= '0;
			ucnt_q <= '0;
			sel_q  <= HEAP_LO;
		end else begin
			case (cmd.op)
				OP_POP_INIT: begin
					sel_q <= cmd.sel;
					if (cmd.sel == HEAP_UP)
						ucnt_q <= ucnt_q - CNT_W'(1);
					else
						lcnt_q <= lcnt_q - CNT_W'(1);
				end
				OP_PUSH_INIT: begin
					sel_q <= cmd.sel;
					if (cmd.sel == HEAP_UP)
						ucnt_q <= ucnt_q + CNT_W'(1);
					else
						lcnt_q <= lcnt_q + CNT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: x_q <= sample;
			OP_POP_INIT: begin
				moved_q <= (cmd.sel == HEAP_UP) ? uptop_q : lotop_q;
				n_q     <= cmd_cnt - CNT_W'(1);
				idx_q   <= '0;
			end
			OP_POP_LOAD: val_q <= rd_a;
			OP_PUSH_INIT: begin
				val_q <= cmd.src_moved ? moved_q : x_q;
				idx_q <= IDX_W'(cmd_cnt);
			end
			OP_POP_STEP, OP_PUSH_STEP: begin
				if (move)
					idx_q <= next_idx;
			end
			OP_EMIT: begin
				median_q  <= med_next;
				dropped_q <= cmd.drop;
				count_q   <= total;
			end
			default: begin
			end
		endcase
		if (we && waddr == '0 && sel_q == HEAP_LO)
			lotop_q <= wdata;
		if (we && waddr == '0 && sel_q == HEAP_UP)
			uptop_q <= wdata;
	end

	assign sum  = {lotop_q[DATA_W-1], lotop_q} + {uptop_q[DATA_W-1], uptop_q};
	assign half = (sum + (DATA_W + 1)'(sum[DATA_W])) >>> 1;

	always_comb begin
		if (lcnt_q == '0 && ucnt_q == '0)
			med_next = '0;
		else if (lcnt_q > ucnt_q)
			med_next = lotop_q;
		else if (ucnt_q > lcnt_q)
			med_next = uptop_q;
		else
			med_next = half[DATA_W-1:0];
	end

	assign status.full       = (total >= TOT_W'(CAPACITY));
	assign status.lo_gt      = (lcnt_q > ucnt_q);
	assign status.up_gt      = (ucnt_q > lcnt_q);
	assign status.lo_nz      = (lcnt_q != '0);
	assign status.x_lt_lotop = (x_q < lotop_q);
	assign status.x_le_lotop = (x_q <= lotop_q);
	assign status.x_gt_uptop = (x_q > uptop_q);
	assign status.pop_empty  = (n_q == '0);
	assign status.step_done  = step_done;

	assign median       = median_q;
	assign dropped      = dropped_q;
	assign stored_count = count_q;

	`RMTH_ASSERT(a_balance, (lcnt_q == ucnt_q) || (lcnt_q == ucnt_q + CNT_W'(1)) || (ucnt_q == lcnt_q + CNT_W'(1)), "heap sizes out of balance")
	`RMTH_ASSERT(a_capacity, total <= TOT_W'(CAPACITY), "store holds more than capacity")
	`RMTH_ASSERT_IMPL(a_push_room, cmd.op == OP_PUSH_INIT, cmd_cnt < CNT_W'(HEAP_DEPTH), "push into full heap")
endmodule

@@ hw/rtl/rmth_ctrl.sv @@
// Sequencer for sample placement, rebalance and output word handshake.
module rmth_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  rmth_pkg::status_t    status,
	output rmth_pkg::cmd_t       cmd
);
	import rmth_pkg::*;

	state_t state_q, state_d;
	heap_t hsel_q, hsel_d, other;
	logic rebal_q, rebal_d, drop_q, drop_d, out_valid_q, emit;

	assign other = (hsel_q == HEAP_LO) ? HEAP_UP : HEAP_LO;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hsel_q      <= HEAP_LO;
			rebal_q     <= 1'b0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			hsel_q      <= hsel_d;
			rebal_q     <= rebal_d;
			drop_q      <= drop_d;
			out_valid_q <= emit | (out_valid_q & out_stall);
		end
	end

	always_comb begin
		state_d       = state_q;
		hsel_d        = hsel_q;
		rebal_d       = rebal_q;
		drop_d        = drop_q;
		emit          = 1'b0;
		cmd.op        = OP_NOP;
		cmd.sel       = hsel_q;
		cmd.src_moved = 1'b0;
		cmd.drop      = drop_q;
		in_stall      = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				drop_d  = 1'b0;
				rebal_d = 1'b0;
				state_d = ST_PUSH_X_INIT;
				if (status.full) begin
					drop_d  = 1'b1;
					state_d = ST_EMIT;
				end else if (status.lo_gt) begin
					hsel_d  = status.x_lt_lotop ? HEAP_LO : HEAP_UP;
					rebal_d = status.x_lt_lotop;
				end else if (status.up_gt) begin
					hsel_d  = status.x_gt_uptop ? HEAP_UP : HEAP_LO;
					rebal_d = status.x_gt_uptop;
				end else begin
					hsel_d = (status.lo_nz && status.x_le_lotop) ? HEAP_LO : HEAP_UP;
				end
				if (!status.full && rebal_d)
					state_d = ST_POP_INIT;
			end
			ST_POP_INIT: begin
				cmd.op  = OP_POP_INIT;
				state_d = ST_POP_LOAD;
			end
			ST_POP_LOAD: begin
				cmd.op  = OP_POP_LOAD;
				state_d = status.pop_empty ? ST_PUSH_M_INIT : ST_POP_STEP;
			end
			ST_POP_STEP: begin
				cmd.op = OP_POP_STEP;
				if (status.step_done)
					state_d = ST_PUSH_M_INIT;
			end
			ST_PUSH_M_INIT: begin
				cmd.op        = OP_PUSH_INIT;
				cmd.sel       = other;
				cmd.src_moved = 1'b1;
				state_d       = ST_PUSH_M_STEP;
			end
			ST_PUSH_M_STEP: begin
				cmd.op = OP_PUSH_STEP;
				if (status.step_done)
					state_d = ST_PUSH_X_INIT;
			end
			ST_PUSH_X_INIT: begin
				cmd.op  = OP_PUSH_INIT;
				state_d = ST_PUSH_X_STEP;
			end
			ST_PUSH_X_STEP: begin
				cmd.op = OP_PUSH_STEP;
				if (status.step_done)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.op  = OP_EMIT;
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;
endmodule

@@ hw/rtl/running_median_two_heaps.sv @@
// Running median top level: controller plus heap datapath.
// Path from accept to output valid: a dropped word goes from decide straight to emit; otherwise
// the sample push follows decide, and with a rebalance a root pop and its push come first.
// One word in flight: no new word is accepted until the last one's output word is emitted, and emit
// waits while a held output word is stalled; the heap memory read and write per level paces each sift.
// Reset clears the counts, controller state and output valid; heap memories are not cleared.
module running_median_two_heaps (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [rmth_pkg::DATA_W-1:0]    sample,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [rmth_pkg::DATA_W-1:0]    median,
	output logic                                  dropped,
	output logic [rmth_pkg::TOT_W-1:0]            stored_count
);
	import rmth_pkg::*;
	`include "running_median_two_heaps_macros.svh"

	cmd_t    cmd;
	status_t status;

	rmth_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	rmth_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.sample       (sample),
		.median       (median),
		.dropped      (dropped),
		.stored_count (stored_count)
	);

	`RMTH_ASSERT_IMPL(a_drop_full, out_valid && dropped, stored_count == TOT_W'(CAPACITY), "drop below capacity")
endmodule
